[sv/upstream_nearest_cell_reallocator_assert.svh]
// Assertion macros for the upstream nearest-cell reallocator.
// Included by the RTL module that checks its own control logic.
`ifndef UPSTREAM_NEAREST_CELL_REALLOCATOR_ASSERT_SVH
`define UPSTREAM_NEAREST_CELL_REALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define UNCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define UNCR_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define UNCR_ASSERT(lbl, prop, msg)
`define UNCR_IMPLY(lbl, ante, cons, msg)
`endif
`endif

[sv/uncr_pkg.sv]
// Shared constants and codes for the upstream nearest-cell reallocator.
// No dependencies.
`default_nettype none
package uncr_pkg;
    localparam int MAX_ROWS   = 128;
    localparam int MAX_COLS   = 128;
    localparam int MAX_RADIUS = 255;
    localparam int ROW_W      = 7;
    localparam int COL_W      = 7;
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int ELEV_W     = 20;
    localparam int POP_W      = 24;
    localparam int VAL_W      = 32;
    localparam int MOVED_W    = 15;
    localparam int IN_W       = 64;
    localparam int OUT_W      = 48;
    localparam int IDX_W      = 3;
    localparam int CFG_W      = 24;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_RUN  = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    localparam logic [IDX_W-1:0] REG_ROWS   = 3'd0;
    localparam logic [IDX_W-1:0] REG_COLS   = 3'd1;
    localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd2;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd3;
    localparam logic [IDX_W-1:0] REG_LIMIT  = 3'd4;
    localparam logic [IDX_W-1:0] REG_RADIUS = 3'd5;
endpackage
`default_nettype wire

[sv/upstream_nearest_cell_reallocator.sv]
// Upstream nearest-cell reallocator: grid store, run sequencer, output store.
// Depends on uncr_pkg and upstream_nearest_cell_reallocator_assert.svh.
//
// channel | signals                     | carries
// s       | s_tvalid s_tready s_tdata   | command and cell data
// m       | m_tvalid m_tready m_tdata   | result of each command
// cfg     | cfg_valid cfg_ready         | register index and value
//
// Read: the value comes through a registered output-store read.
// Run: the population store is first copied into the output store, then each grid
// cell is visited; a cell that searches scans each window row and cell, computes the
// distance of each qualifying river cell and may make a move; the single shared 24x24
// multiplier and the one read port of each store serve all of these steps.
// rst_n clears the control state only; store contents are undefined until loaded.
// Results wait in an output register; a new command is taken once it drains.
`default_nettype none
`include "upstream_nearest_cell_reallocator_assert.svh"
module upstream_nearest_cell_reallocator (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // operation[1:0] row[8:2] col[15:9] elevation[35:16] is_river[36]
    // population[60:37], zero[63:61]
    input  wire logic [uncr_pkg::IN_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // cell_value[31:0] moved_cells[46:32] saturated[47]
    output logic [uncr_pkg::OUT_W-1:0]       m_tdata,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [uncr_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [uncr_pkg::CFG_W-1:0]  cfg_data
);
    import uncr_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RD_DONE, ST_LIM, ST_COPY_RD, ST_COPY_WR, ST_SRC_RD, ST_SRC_CHK,
        ST_ROW_MUL, ST_ROW_SQ, ST_WIN_RD, ST_WIN_CHK, ST_MUL_X, ST_MUL_SQ, ST_CMP,
        ST_MOVE, ST_ACC, ST_ZERO, ST_NEXT, ST_FINISH
    } state_t;

    localparam int CELL_W = ELEV_W + 1 + POP_W;

    logic [CELL_W-1:0] cell_mem [MAX_ROWS*MAX_COLS];
    logic [VAL_W-1:0]  out_mem  [MAX_ROWS*MAX_COLS];

    state_t state_reg, state_next;
    logic [7:0]  rows_reg, cols_reg, radius_reg;
    logic [15:0] width_reg, height_reg;
    logic [23:0] limit_reg;
    logic [47:0] lim2_reg, ay2_reg, ax2_reg;
    logic [23:0] ay_reg, ax_reg;
    logic [48:0] best_reg;
    logic [ADDR_W-1:0] dest_reg, copy_reg;
    logic found_reg, copy_last_reg, sat_reg, m_tvalid_reg;
    logic [ROW_W-1:0] r_reg, wr_reg, whi_reg;
    logic [COL_W-1:0] c_reg, wc_reg, chi_reg, clo_reg;
    logic signed [ELEV_W-1:0] h_reg;
    logic [POP_W-1:0] pop_reg;
    logic [MOVED_W-1:0] moved_reg;
    logic [OUT_W-1:0] m_tdata_reg;
    logic [CELL_W-1:0] cell_rd_reg;
    logic [VAL_W-1:0]  out_rd_reg;

    logic [1:0] in_op;
    logic [ADDR_W-1:0] in_addr;
    logic accept;
    logic res_load;
    logic [7:0] nr, nc, rad;
    logic signed [ELEV_W-1:0] rd_elev;
    logic rd_river;
    logic [POP_W-1:0] rd_pop;
    logic [23:0] mul_a, mul_b;
    logic [47:0] mul_p;
    logic [7:0] dabs;
    logic [8:0] hi_sum_r, hi_sum_c;
    logic [48:0] d2;
    logic [32:0] acc_sum;
    logic cell_rd_en, out_rd_en, out_wr_en;
    logic [ADDR_W-1:0] cell_rd_addr, out_rd_addr, out_wr_addr;
    logic [VAL_W-1:0] out_wr_data;

    assign in_op   = s_tdata[1:0];
    assign in_addr = {s_tdata[8:2], s_tdata[15:9]};
    assign s_tready  = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign res_load = (state_reg == ST_IDLE && accept && (in_op == OP_LOAD || in_op == OP_NONE))
                      || state_reg == ST_RD_DONE || state_reg == ST_FINISH;

    assign nr  = (rows_reg > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : rows_reg;
    assign nc  = (cols_reg > 8'(MAX_COLS)) ? 8'(MAX_COLS) : cols_reg;
    assign rad = (radius_reg > 8'(MAX_RADIUS)) ? 8'(MAX_RADIUS) : radius_reg;

    assign rd_elev  = cell_rd_reg[ELEV_W-1:0];
    assign rd_river = cell_rd_reg[ELEV_W];
    assign rd_pop   = cell_rd_reg[CELL_W-1:ELEV_W+1];

    assign hi_sum_r = {2'b0, r_reg} + {1'b0, rad};
    assign hi_sum_c = {2'b0, c_reg} + {1'b0, rad};

    // shared multiplier operands
    always_comb
    begin
        dabs  = '0;
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_LIM:
            begin
                mul_a = limit_reg;
                mul_b = limit_reg;
            end
            ST_ROW_MUL:
            begin
                dabs  = (wr_reg >= r_reg) ? {1'b0, wr_reg - r_reg} : {1'b0, r_reg - wr_reg};
                mul_a = {16'b0, dabs};
                mul_b = {8'b0, height_reg};
            end
            ST_ROW_SQ:
            begin
                mul_a = ay_reg;
                mul_b = ay_reg;
            end
            ST_MUL_X:
            begin
                dabs  = (wc_reg >= c_reg) ? {1'b0, wc_reg - c_reg} : {1'b0, c_reg - wc_reg};
                mul_a = {16'b0, dabs};
                mul_b = {8'b0, width_reg};
            end
            ST_MUL_SQ:
            begin
                mul_a = ax_reg;
                mul_b = ax_reg;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign d2      = {1'b0, ax2_reg} + {1'b0, ay2_reg};
    assign acc_sum = {1'b0, out_rd_reg} + {9'b0, pop_reg};

    // memory port selection
    always_comb
    begin
        cell_rd_en   = 1'b0;
        cell_rd_addr = copy_reg;
        out_rd_en    = 1'b0;
        out_rd_addr  = in_addr;
        out_wr_en    = 1'b0;
        out_wr_addr  = copy_reg;
        out_wr_data  = {8'b0, rd_pop};
        unique case (state_reg)
            ST_IDLE:
            begin
                out_rd_en = accept && (in_op == OP_READ);
            end
            ST_COPY_RD:
            begin
                cell_rd_en = 1'b1;
            end
            ST_COPY_WR:
            begin
                out_wr_en = 1'b1;
            end
            ST_SRC_RD:
            begin
                cell_rd_en   = 1'b1;
                cell_rd_addr = {r_reg, c_reg};
            end
            ST_WIN_RD:
            begin
                cell_rd_en   = 1'b1;
                cell_rd_addr = {wr_reg, wc_reg};
            end
            ST_MOVE:
            begin
                out_rd_en   = found_reg;
                out_rd_addr = dest_reg;
            end
            ST_ACC:
            begin
                out_wr_en   = 1'b1;
                out_wr_addr = dest_reg;
                out_wr_data = acc_sum[VAL_W] ? '1 : acc_sum[VAL_W-1:0];
            end
            ST_ZERO:
            begin
                out_wr_en   = 1'b1;
                out_wr_addr = {r_reg, c_reg};
                out_wr_data = '0;
            end
            default:
            begin
                cell_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept && (in_op == OP_LOAD))
        begin
            cell_mem[in_addr] <= {s_tdata[60:37], s_tdata[36], s_tdata[35:16]};
        end
        if (cell_rd_en)
        begin
            cell_rd_reg <= cell_mem[cell_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_wr_en)
        begin
            out_mem[out_wr_addr] <= out_wr_data;
        end
        if (out_rd_en)
        begin
            out_rd_reg <= out_mem[out_rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_op == OP_READ))
                begin
                    state_next = ST_RD_DONE;
                end
                else if (accept && (in_op == OP_RUN))
                begin
                    state_next = ST_LIM;
                end
            end
            ST_RD_DONE: state_next = ST_IDLE;
            ST_LIM:     state_next = ST_COPY_RD;
            ST_COPY_RD: state_next = ST_COPY_WR;
            ST_COPY_WR:
            begin
                if (!copy_last_reg)
                begin
                    state_next = ST_COPY_RD;
                end
                else if (nr == 8'd0 || nc == 8'd0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SRC_RD;
                end
            end
            ST_SRC_RD: state_next = ST_SRC_CHK;
            ST_SRC_CHK:
            begin
                if (rd_pop == '0 || rd_river)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    state_next = ST_ROW_MUL;
                end
            end
            ST_ROW_MUL: state_next = ST_ROW_SQ;
            ST_ROW_SQ:  state_next = ST_WIN_RD;
            ST_WIN_RD:  state_next = ST_WIN_CHK;
            ST_WIN_CHK,
            ST_CMP:
            begin
                if (state_reg == ST_WIN_CHK && rd_river && (rd_elev >= h_reg))
                begin
                    state_next = ST_MUL_X;
                end
                else if (wc_reg != chi_reg)
                begin
                    state_next = ST_WIN_RD;
                end
                else if (wr_reg != whi_reg)
                begin
                    state_next = ST_ROW_MUL;
                end
                else
                begin
                    state_next = ST_MOVE;
                end
            end
            ST_MUL_X:  state_next = ST_MUL_SQ;
            ST_MUL_SQ: state_next = ST_CMP;
            ST_MOVE:   state_next = found_reg ? ST_ACC : ST_NEXT;
            ST_ACC:    state_next = ST_ZERO;
            ST_ZERO:   state_next = ST_NEXT;
            ST_NEXT:
            begin
                if ({1'b0, c_reg} == nc - 8'd1 && {1'b0, r_reg} == nr - 8'd1)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SRC_RD;
                end
            end
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rows_reg      <= 8'd128;
            cols_reg      <= 8'd128;
            width_reg     <= 16'd1000;
            height_reg    <= 16'd1000;
            limit_reg     <= 24'd20000;
            radius_reg    <= 8'd21;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            copy_reg      <= '0;
            copy_last_reg <= 1'b0;
            found_reg     <= 1'b0;
            sat_reg       <= 1'b0;
            moved_reg     <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_ROWS:   rows_reg   <= cfg_data[7:0];
                    REG_COLS:   cols_reg   <= cfg_data[7:0];
                    REG_WIDTH:  width_reg  <= cfg_data[15:0];
                    REG_HEIGHT: height_reg <= cfg_data[15:0];
                    REG_LIMIT:  limit_reg  <= cfg_data;
                    REG_RADIUS: radius_reg <= cfg_data[7:0];
                    default:    rows_reg   <= rows_reg;
                endcase
            end
            if (res_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (in_op == OP_LOAD || in_op == OP_NONE))
                    begin
                        m_tdata_reg <= '0;
                    end
                end
                ST_RD_DONE:
                begin
                    m_tdata_reg <= {16'b0, out_rd_reg};
                end
                ST_LIM:
                begin
                    lim2_reg      <= mul_p;
                    copy_reg      <= '0;
                    copy_last_reg <= 1'b0;
                    moved_reg     <= '0;
                    sat_reg       <= 1'b0;
                    r_reg         <= '0;
                    c_reg         <= '0;
                end
                ST_COPY_WR:
                begin
                    copy_reg      <= copy_reg + 1'b1;
                    copy_last_reg <= (copy_reg == {{(ADDR_W-1){1'b1}}, 1'b0});
                end
                ST_SRC_CHK:
                begin
                    h_reg     <= rd_elev;
                    pop_reg   <= rd_pop;
                    best_reg  <= {1'b0, lim2_reg};
                    found_reg <= 1'b0;
                    wr_reg    <= ({1'b0, r_reg} > rad) ? r_reg - rad[ROW_W-1:0] : '0;
                    whi_reg   <= (hi_sum_r > {1'b0, nr} - 9'd1) ? nr[ROW_W-1:0] - 1'b1
                                                               : hi_sum_r[ROW_W-1:0];
                    clo_reg   <= ({1'b0, c_reg} > rad) ? c_reg - rad[COL_W-1:0] : '0;
                    wc_reg    <= ({1'b0, c_reg} > rad) ? c_reg - rad[COL_W-1:0] : '0;
                    chi_reg   <= (hi_sum_c > {1'b0, nc} - 9'd1) ? nc[COL_W-1:0] - 1'b1
                                                               : hi_sum_c[COL_W-1:0];
                end
                ST_ROW_MUL:
                begin
                    ay_reg <= mul_p[23:0];
                end
                ST_ROW_SQ:
                begin
                    ay2_reg <= mul_p;
                    wc_reg  <= clo_reg;
                end
                ST_MUL_X:
                begin
                    ax_reg <= mul_p[23:0];
                end
                ST_MUL_SQ:
                begin
                    ax2_reg <= mul_p;
                end
                ST_FINISH:
                begin
                    m_tdata_reg <= {sat_reg, moved_reg, 32'b0};
                end
                default:
                begin
                    m_tdata_reg <= m_tdata_reg;
                end
            endcase
            if (state_reg == ST_CMP && d2 < best_reg)
            begin
                best_reg  <= d2;
                dest_reg  <= {wr_reg, wc_reg};
                found_reg <= 1'b1;
            end
            if (state_reg == ST_WIN_CHK || state_reg == ST_CMP)
            begin
                if (state_next == ST_WIN_RD)
                begin
                    wc_reg <= wc_reg + 1'b1;
                end
                else if (state_next == ST_ROW_MUL)
                begin
                    wr_reg <= wr_reg + 1'b1;
                end
            end
            if (state_reg == ST_ACC)
            begin
                if (acc_sum[VAL_W])
                begin
                    sat_reg <= 1'b1;
                end
                if (moved_reg != '1)
                begin
                    moved_reg <= moved_reg + 1'b1;
                end
            end
            if (state_reg == ST_NEXT)
            begin
                if ({1'b0, c_reg} == nc - 8'd1)
                begin
                    c_reg <= '0;
                    r_reg <= r_reg + 1'b1;
                end
                else
                begin
                    c_reg <= c_reg + 1'b1;
                end
            end
        end
    end

    `UNCR_IMPLY(a_ready_idle, s_tready, state_reg == ST_IDLE, "ready outside idle")
    `UNCR_IMPLY(a_no_overwrite, state_reg == ST_RD_DONE || state_reg == ST_FINISH,
        !m_tvalid_reg, "result register overwritten")
    `UNCR_IMPLY(a_win_in_grid, state_reg == ST_WIN_RD,
        {1'b0, wr_reg} < nr && {1'b0, wc_reg} < nc, "window outside grid")
    `UNCR_IMPLY(a_move_found, state_reg == ST_ACC, $past(found_reg), "move without target")

endmodule
`default_nettype wire

[bench/tb.sv]
// Self-checking bench for upstream_nearest_cell_reallocator: loads grids, runs passes,
// reads cells back and checks every result against a built-in reallocation predictor.
// Depends on uncr_pkg and the RTL top level.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import uncr_pkg::*;

    typedef struct {
        uncr_pkg::op_t      op;
        logic [6:0]         row;
        logic [6:0]         col;
        logic signed [19:0] elev;
        logic               river;
        logic [23:0]        pop;
    } cell_cmd_t;

    typedef struct {
        logic [31:0] value;
        logic [14:0] moved;
        logic        sat;
    } cell_result_t;

    class reallocation_scoreboard;
        logic signed [19:0] elev_store[16384];
        logic               river_store[16384];
        logic [23:0]        pop_store[16384];
        logic [31:0]        out_store[16384];
        int unsigned        grid_rows, grid_cols, cell_width, cell_height, dist_limit, radius;
        cell_result_t       pending_results[$];
        int                 errors;

        function new();
            grid_rows = 128;
            grid_cols = 128;
            cell_width = 1000;
            cell_height = 1000;
            dist_limit = 20000;
            radius = 21;
            errors = 0;
            for (int i = 0; i < 16384; i++)
            begin
                elev_store[i] = '0;
                river_store[i] = 1'b0;
                pop_store[i] = '0;
                out_store[i] = '0;
            end
        endfunction

        function void write_register(logic [2:0] idx, logic [23:0] val);
            case (idx)
                uncr_pkg::REG_ROWS:   grid_rows = val[7:0];
                uncr_pkg::REG_COLS:   grid_cols = val[7:0];
                uncr_pkg::REG_WIDTH:  cell_width = val[15:0];
                uncr_pkg::REG_HEIGHT: cell_height = val[15:0];
                uncr_pkg::REG_LIMIT:  dist_limit = val;
                uncr_pkg::REG_RADIUS: radius = val[7:0];
                default: ;
            endcase
        endfunction

        function void reallocate(output int moved, output bit sat);
            int rows, cols, rad, src, dest, k, di0, di1, dj0, dj1;
            longint unsigned lim2, best, ax, ay, d2, sum;
            rows = (grid_rows > 128) ? 128 : grid_rows;
            cols = (grid_cols > 128) ? 128 : grid_cols;
            rad = (radius > 255) ? 255 : radius;
            lim2 = longint'(dist_limit) * longint'(dist_limit);
            moved = 0;
            sat = 1'b0;
            for (int i = 0; i < 16384; i++)
                out_store[i] = {8'd0, pop_store[i]};
            for (int r = 0; r < rows; r++)
            begin
                for (int c = 0; c < cols; c++)
                begin
                    src = r * 128 + c;
                    if (pop_store[src] == 0 || river_store[src])
                        continue;
                    best = lim2;
                    dest = -1;
                    di0 = (-rad < -r) ? -r : -rad;
                    di1 = (rad > rows - 1 - r) ? rows - 1 - r : rad;
                    dj0 = (-rad < -c) ? -c : -rad;
                    dj1 = (rad > cols - 1 - c) ? cols - 1 - c : rad;
                    for (int di = di0; di <= di1; di++)
                    begin
                        ay = longint'(di < 0 ? -di : di) * cell_height;
                        for (int dj = dj0; dj <= dj1; dj++)
                        begin
                            k = (r + di) * 128 + (c + dj);
                            if (!river_store[k] || elev_store[k] < elev_store[src])
                                continue;
                            ax = longint'(dj < 0 ? -dj : dj) * cell_width;
                            d2 = ax * ax + ay * ay;
                            if (d2 < best)
                            begin
                                best = d2;
                                dest = k;
                            end
                        end
                    end
                    if (dest >= 0)
                    begin
                        sum = longint'(out_store[dest]) + longint'(out_store[src]);
                        if (sum > 64'hFFFF_FFFF)
                        begin
                            sum = 64'hFFFF_FFFF;
                            sat = 1'b1;
                        end
                        out_store[dest] = sum[31:0];
                        out_store[src] = '0;
                        if (moved < 32'h7FFF)
                            moved++;
                    end
                end
            end
        endfunction

        function void note_command(cell_cmd_t cmd);
            cell_result_t res;
            int moved, addr;
            bit sat;
            res = '{value: '0, moved: '0, sat: 1'b0};
            addr = {cmd.row, cmd.col};
            case (cmd.op)
                uncr_pkg::OP_LOAD:
                begin
                    elev_store[addr] = cmd.elev;
                    river_store[addr] = cmd.river;
                    pop_store[addr] = cmd.pop;
                end
                uncr_pkg::OP_RUN:
                begin
                    reallocate(moved, sat);
                    res.moved = moved[14:0];
                    res.sat = sat;
                end
                uncr_pkg::OP_READ: res.value = out_store[addr];
                default: ;
            endcase
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [47:0] data);
            cell_result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected transfer %h", $time, data);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (data[31:0] !== want.value)
            begin
                $display("%0t cell_value expected %h actual %h", $time, want.value, data[31:0]);
                errors++;
            end
            if (data[46:32] !== want.moved)
            begin
                $display("%0t moved_cells expected %0d actual %0d", $time, want.moved,
                         data[46:32]);
                errors++;
            end
            if (data[47] !== want.sat)
            begin
                $display("%0t saturated expected %b actual %b", $time, want.sat, data[47]);
                errors++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 1000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    reallocation_scoreboard sb = new();
    bit  quiet = 1'b0;
    bit  pressure_req = 1'b0;
    int  hold_left = 0;
    int  stall_cycles = 0;
    bit  cell_loaded[16384];
    int  loaded_q[$];
    int  readable_q[$];

    always #2 clk = ~clk;

    upstream_nearest_cell_reallocator u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always @(negedge clk)
    begin
        if (pressure_req)
        begin
            pressure_req <= 1'b0;
            hold_left <= 600;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            hold_left <= $urandom_range(0, 11);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_cmd(cell_cmd_t cmd);
        int addr;
        addr = {cmd.row, cmd.col};
        @(negedge clk);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, cmd.pop, cmd.river, cmd.elev, cmd.col, cmd.row, cmd.op};
        do @(posedge clk); while (!s_tready);
        sb.note_command(cmd);
        if (cmd.op == OP_LOAD && !cell_loaded[addr])
        begin
            cell_loaded[addr] = 1'b1;
            loaded_q.push_back(addr);
        end
        if (cmd.op == OP_RUN)
            readable_q = loaded_q;
    endtask

    task automatic send_load(int r, int c, logic signed [19:0] elev, logic river, logic [23:0] pop);
        send_cmd('{op: OP_LOAD, row: r[6:0], col: c[6:0], elev: elev, river: river, pop: pop});
    endtask

    task automatic send_run();
        send_cmd('{op: OP_RUN, row: '0, col: '0, elev: '0, river: 1'b0, pop: '0});
    endtask

    task automatic send_read(int addr);
        send_cmd('{op: OP_READ, row: addr[13:7], col: addr[6:0], elev: '0, river: 1'b0, pop: '0});
    endtask

    task automatic send_random_cell(int r, int c);
        logic signed [19:0] elev;
        logic [23:0] pop;
        elev = ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($signed($urandom_range(0, 40)) - 20);
        case ($urandom_range(0, 9))
            0, 1: pop = '0;
            2: pop = 24'hFF_FFFF;
            default: pop = 24'($urandom);
        endcase
        send_load(r, c, elev, $urandom_range(0, 3) == 0, pop);
    endtask

    task automatic send_random_extra();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 9 && readable_q.size() > 0)
            send_read(readable_q[$urandom_range(0, readable_q.size() - 1)]);
        else if (pick < 11)
            send_cmd('{op: OP_NONE, row: 7'($urandom), col: 7'($urandom), elev: 20'($urandom),
                       river: 1'($urandom), pop: 24'($urandom)});
        else
            send_random_cell($urandom_range(0, 127), $urandom_range(0, 127));
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, int unsigned val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[23:0];
        do @(posedge clk); while (!cfg_ready);
        sb.write_register(idx, val[23:0]);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(int rows, int cols, int w, int h, int lim, int rad);
        settle();
        write_reg(REG_ROWS, rows);
        write_reg(REG_COLS, cols);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_LIMIT, lim);
        write_reg(REG_RADIUS, rad);
    endtask

    task automatic run_phase(int rows, int cols, int w, int h, int lim, int rad,
                             int pre, int post, bit press);
        configure(rows, cols, w, h, lim, rad);
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < cols; c++)
                send_random_cell(r, c);
        if (press)
            pressure_req = 1'b1;
        repeat (pre) send_random_extra();
        send_run();
        repeat (post) send_random_extra();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        configure(2, 2, 1000, 1000, 20000, 1);
        send_load(0, 0, -20'sd524288, 1'b0, 24'hFF_FFFF);
        send_load(0, 1, 20'sd524287, 1'b1, 24'h00_0000);
        send_load(1, 0, 20'sd0, 1'b0, 24'h00_0001);
        send_load(1, 1, 20'sd0, 1'b1, 24'h00_0064);
        send_load(127, 127, 20'sd12345, 1'b0, 24'hAB_CDEF);
        send_load(127, 0, -20'sd1, 1'b1, 24'h55_AA55);
        send_cmd('{op: OP_NONE, row: 7'd127, col: 7'd127, elev: -20'sd1, river: 1'b1,
                   pop: 24'hFF_FFFF});
        send_run();
        send_read(0);
        send_read(1);
        send_read(128);
        send_read(129);
        send_read(16383);
        send_read(16256);
        send_cmd('{op: OP_NONE, row: '0, col: '0, elev: '0, river: 1'b0, pop: '0});

        run_phase(8, 8, 1000, 1000, 20000, 21, 30, 40, 1'b1);
        run_phase(1, 128, 65535, 1, 16777215, 255, 10, 20, 1'b0);
        run_phase(128, 1, 0, 0, 5, 3, 10, 20, 1'b0);
        run_phase(0, 5, 1000, 1000, 0, 4, 10, 20, 1'b0);
        run_phase(6, 10, 300, 700, 2000, 0, 20, 20, 1'b0);

        configure(17, 17, 1, 1, 16777215, 255);
        for (int r = 0; r < 17; r++)
            for (int c = 0; c < 17; c++)
                if (r == 8 && c == 8)
                    send_load(r, c, 20'sd524287, 1'b1, 24'hFF_FFFF);
                else
                    send_load(r, c, -20'sd524288, 1'b0, 24'hFF_FFFF);
        send_run();
        repeat (10) send_random_extra();

        for (int p = 0; p < 5; p++)
        begin
            if (p >= 3)
                quiet = 1'b1;
            run_phase($urandom_range(1, 10), $urandom_range(1, 10),
                      $urandom_range(0, 4000), $urandom_range(0, 4000),
                      ($urandom_range(0, 3) == 0) ? ($urandom & 24'hFF_FFFF)
                                                   : $urandom_range(0, 30000),
                      $urandom_range(0, 6), 20, 30, 1'b0);
        end

        settle();
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

`default_nettype wire

[sim.f]
+incdir+sv
sv/uncr_pkg.sv
sv/upstream_nearest_cell_reallocator.sv
bench/tb.sv
